// ===== design/brft_pkg.sv =====
// Shared types, character codes, phase codes and result builders of the brace record tokenizer.
package brft_pkg;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // parser phases
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_FWS   = 3'd1;
    localparam logic [2:0] PH_FIELD = 3'd2;
    localparam logic [2:0] PH_ESC   = 3'd3;
    localparam logic [2:0] PH_SEEK  = 3'd4;
    localparam logic [2:0] PH_DEAD  = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_OK    = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NO_LEADER  = 3'd0;
    localparam logic [2:0] ERR_BAD_TERM   = 3'd1;
    localparam logic [2:0] ERR_UNTERM     = 3'd2;
    localparam logic [2:0] ERR_MISMATCH   = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW   = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] field_start;
        logic [11:0] field_length;
        logic [7:0]  record_number;
        logic [7:0]  field_number;
        logic        closes_record;
        logic [2:0]  error_code;
        logic [7:0]  record_total;
        logic [7:0]  fields_each;
        logic [12:0] char_total;
        logic        last;
    } t_result;

    // up to two results written into the output queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_result    d0;
        t_result    d1;
    } t_push;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
    endfunction

    function automatic t_result mk_token(input logic [11:0] start, input logic [11:0] len,
                                         input logic [7:0] rec, input logic [7:0] fld,
                                         input logic closes);
        t_result r;
        r = '0;
        r.kind          = KIND_TOKEN;
        r.field_start   = start;
        r.field_length  = len;
        r.record_number = rec;
        r.field_number  = fld;
        r.closes_record = closes;
        return r;
    endfunction

    function automatic t_result mk_status(input logic ok, input logic [2:0] code,
                                          input logic [7:0] rec, input logic [7:0] fexp,
                                          input logic [12:0] csum);
        t_result r;
        r = '0;
        r.kind         = ok ? KIND_OK : KIND_ERR;
        r.error_code   = ok ? ERR_NO_LEADER : code;
        r.record_total = rec;
        r.fields_each  = fexp;
        r.char_total   = csum;
        return r;
    endfunction

endpackage

// ===== design/brft_in_if.sv =====
// Character input channel.
interface brft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

// ===== design/brft_out_if.sv =====
// Result output channel.
interface brft_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] field_start;
    logic [11:0] field_length;
    logic [7:0]  record_number;
    logic [7:0]  field_number;
    logic        closes_record;
    logic [2:0]  error_code;
    logic [7:0]  record_total;
    logic [7:0]  fields_each;
    logic [12:0] char_total;
    logic        last;

    modport source (output valid, output kind, output field_start, output field_length,
                    output record_number, output field_number, output closes_record,
                    output error_code, output record_total, output fields_each,
                    output char_total, output last, input ready);
    modport sink   (input valid, input kind, input field_start, input field_length,
                    input record_number, input field_number, input closes_record,
                    input error_code, input record_total, input fields_each,
                    input char_total, input last, output ready);
endinterface

// ===== design/brft_out_queue.sv =====
// Four-entry result queue taking up to two results per cycle.
module brft_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brft_pkg::t_push   i_push,
    input  logic              i_pop,
    output brft_pkg::t_result o_head,
    output logic              o_valid,
    output logic [2:0]        o_count
);
    import brft_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic [1:0] w_wp1;

    assign w_wp1   = r_wp + 2'd1;
    assign o_head  = r_mem[r_rp];
    assign o_valid = (r_cnt != 3'd0);
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.d0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[w_wp1] <= i_push.d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_push.cnt;
            r_rp  <= r_rp + {1'b0, i_pop};
            r_cnt <= r_cnt + {1'b0, i_push.cnt} - {2'b0, i_pop};
        end
    end

endmodule

// ===== design/brace_record_field_tokenizer_top.sv =====
// Brace record field tokenizer: character stage, parser and result queue.
//
// Takes one character per cycle and reports each field of a {a, b}{c, d} string as a token,
// then one status result at the zero that ends the string or at the first error. A character
// is taken into an input register; from there the parser updates its counters and writes
// the zero, one or two results it causes into a four-entry queue, so throughput is one
// character per cycle as long as the queue holds no more than two results. A result is valid
// on the output once the parser has written it into the queue. MAX_CHARS,
// MAX_RECORDS and MAX_FIELDS set the overflow limits and the counter widths.
module brace_record_field_tokenizer_top #(
    parameter int MAX_CHARS   = 4096,
    parameter int MAX_RECORDS = 256,
    parameter int MAX_FIELDS  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brft_in_if.sink     i_in,
    brft_out_if.source  o_out
);
    import brft_pkg::*;

    localparam int PW = $clog2(MAX_CHARS);
    localparam int RW = $clog2(MAX_RECORDS);
    localparam int FW = $clog2(MAX_FIELDS);

    // input stage
    logic          r_in_valid;
    logic [7:0]    r_char;

    // parser state
    logic [2:0]    r_phase,  n_phase;
    logic [PW-1:0] r_pos,    n_pos;
    logic [PW-1:0] r_tstart, n_tstart;
    logic [PW-1:0] r_smark,  n_smark;
    logic          r_smv,    n_smv;
    logic [FW-1:0] r_fcnt,   n_fcnt;
    logic [RW-1:0] r_rcnt,   n_rcnt;
    logic [FW-1:0] r_fexp,   n_fexp;
    logic [12:0]   r_csum,   n_csum;

    logic          w_fire;
    logic [2:0]    w_qcount;
    logic          w_qvalid;
    t_result       w_head;
    t_push         w_push;
    t_result       v_res0, v_res1;
    logic [1:0]    v_nres;
    logic [PW-1:0] v_stop;
    logic [PW-1:0] v_len;
    logic          v_go;

    assign w_fire     = r_in_valid && (w_qcount <= 3'd2);
    assign i_in.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_char <= i_in.char_code;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_tstart = r_tstart;
        n_smark  = r_smark;
        n_smv    = r_smv;
        n_fcnt   = r_fcnt;
        n_rcnt   = r_rcnt;
        n_fexp   = r_fexp;
        n_csum   = r_csum;
        v_res0   = '0;
        v_res1   = '0;
        v_nres   = 2'd0;
        v_stop   = '0;
        v_len    = '0;
        v_go     = 1'b0;

        if (r_char == CH_NUL) begin
            // end of string
            case (r_phase)
                PH_START: begin
                    v_res0 = mk_status(r_pos == '0, ERR_NO_LEADER, 8'(32'(r_rcnt)),
                                       8'(32'(r_fexp)), r_csum);
                    v_nres = 2'd1;
                end
                PH_FWS: begin
                    if (r_pos == r_tstart) begin
                        if ((32'(r_rcnt) + 32'd1) >= 32'(MAX_RECORDS)) begin
                            v_res0 = mk_status(1'b0, ERR_OVERFLOW, 8'(32'(r_rcnt)),
                                               8'(32'(r_fexp)), r_csum);
                        end else begin
                            n_rcnt = r_rcnt + 1'b1;
                            v_res0 = mk_status(1'b0, ERR_UNTERM, 8'(32'(n_rcnt)),
                                               8'(32'(r_fexp)), r_csum);
                        end
                    end else begin
                        n_csum = r_csum + 13'd1;
                        v_res0 = mk_status(1'b0, ERR_BAD_TERM, 8'(32'(r_rcnt)),
                                           8'(32'(r_fexp)), n_csum);
                    end
                    v_nres = 2'd1;
                end
                PH_FIELD, PH_ESC: begin
                    v_stop = (r_phase == PH_FIELD && r_smv) ? r_smark : r_pos;
                    v_len  = v_stop - r_tstart;
                    n_csum = r_csum + 13'(32'(v_len)) + 13'd1;
                    v_res0 = mk_status(1'b0, ERR_BAD_TERM, 8'(32'(r_rcnt)),
                                       8'(32'(r_fexp)), n_csum);
                    v_nres = 2'd1;
                end
                PH_SEEK: begin
                    v_res0 = mk_status(1'b1, ERR_NO_LEADER, 8'(32'(r_rcnt)),
                                       8'(32'(r_fexp)), r_csum);
                    v_nres = 2'd1;
                end
                default: begin
                end
            endcase
            // rearm
            n_phase  = PH_START;
            n_pos    = '0;
            n_tstart = '0;
            n_smark  = '0;
            n_smv    = 1'b0;
            n_fcnt   = '0;
            n_rcnt   = '0;
            n_fexp   = '0;
            n_csum   = '0;
        end else if (r_phase >= PH_DEAD) begin
            // ignore until end of string
        end else if (32'(r_pos) >= 32'(MAX_CHARS - 1)) begin
            v_res0  = mk_status(1'b0, ERR_OVERFLOW, 8'(32'(r_rcnt)), 8'(32'(r_fexp)), r_csum);
            v_nres  = 2'd1;
            n_phase = PH_DEAD;
        end else begin
            n_pos = r_pos + 1'b1;
            case (r_phase)
                PH_START, PH_SEEK: begin
                    if (r_char == CH_LBRACE) begin
                        n_phase  = PH_FWS;
                        n_fcnt   = '0;
                        n_tstart = r_pos + 1'b1;
                    end else if (r_phase == PH_START && !is_space(r_char)) begin
                        v_res0  = mk_status(1'b0, ERR_NO_LEADER, 8'(32'(r_rcnt)),
                                            8'(32'(r_fexp)), r_csum);
                        v_nres  = 2'd1;
                        n_phase = PH_DEAD;
                    end
                end
                PH_FWS: begin
                    if (!is_space(r_char)) begin
                        n_tstart = r_pos;
                        n_smv    = 1'b0;
                        n_phase  = PH_FIELD;
                        v_go     = 1'b1;
                    end
                end
                PH_ESC: begin
                    n_phase = PH_FIELD;
                end
                default: begin
                    v_go = 1'b1;
                end
            endcase

            if (v_go) begin
                if (r_char == CH_BSLASH) begin
                    n_smv   = 1'b0;
                    n_phase = PH_ESC;
                end else if (r_char == CH_COMMA || r_char == CH_RBRACE) begin
                    // field ends here
                    v_stop = n_smv ? n_smark : r_pos;
                    v_len  = v_stop - n_tstart;
                    if ((32'(r_fcnt) + 32'd1) >= 32'(MAX_FIELDS)) begin
                        v_res0  = mk_status(1'b0, ERR_OVERFLOW, 8'(32'(r_rcnt)),
                                            8'(32'(r_fexp)), r_csum);
                        v_nres  = 2'd1;
                        n_phase = PH_DEAD;
                    end else begin
                        n_csum = r_csum + 13'(32'(v_len)) + 13'd1;
                        v_res0 = mk_token(12'(32'(n_tstart)), 12'(32'(v_len)),
                                          8'(32'(r_rcnt)), 8'(32'(r_fcnt)),
                                          r_char == CH_RBRACE);
                        v_nres = 2'd1;
                        n_fcnt = r_fcnt + 1'b1;
                        if (r_char == CH_COMMA) begin
                            n_phase  = PH_FWS;
                            n_tstart = r_pos + 1'b1;
                        end else if ((32'(r_rcnt) + 32'd1) >= 32'(MAX_RECORDS)) begin
                            v_res1  = mk_status(1'b0, ERR_OVERFLOW, 8'(32'(r_rcnt)),
                                                8'(32'(r_fexp)), n_csum);
                            v_nres  = 2'd2;
                            n_phase = PH_DEAD;
                        end else begin
                            n_rcnt  = r_rcnt + 1'b1;
                            n_phase = PH_SEEK;
                            if (r_fexp == '0) begin
                                n_fexp = n_fcnt;
                            end else if (r_fexp != n_fcnt) begin
                                v_res1  = mk_status(1'b0, ERR_MISMATCH, 8'(32'(n_rcnt)),
                                                    8'(32'(r_fexp)), n_csum);
                                v_nres  = 2'd2;
                                n_phase = PH_DEAD;
                            end
                        end
                    end
                end else if (is_space(r_char)) begin
                    // trailing whitespace starts at the first blank of a run
                    if (!n_smv) begin
                        n_smark = r_pos;
                        n_smv   = 1'b1;
                    end
                end else begin
                    n_smv = 1'b0;
                end
            end
        end

        if (v_nres == 2'd1) begin
            v_res0.last = 1'b1;
        end
        if (v_nres == 2'd2) begin
            v_res1.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_pos    <= '0;
            r_tstart <= '0;
            r_smark  <= '0;
            r_smv    <= 1'b0;
            r_fcnt   <= '0;
            r_rcnt   <= '0;
            r_fexp   <= '0;
            r_csum   <= '0;
        end else if (w_fire) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_smark  <= n_smark;
            r_smv    <= n_smv;
            r_fcnt   <= n_fcnt;
            r_rcnt   <= n_rcnt;
            r_fexp   <= n_fexp;
            r_csum   <= n_csum;
        end
    end

    assign w_push.cnt = w_fire ? v_nres : 2'd0;
    assign w_push.d0  = v_res0;
    assign w_push.d1  = v_res1;

    brft_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_qvalid && o_out.ready),
        .o_head  (w_head),
        .o_valid (w_qvalid),
        .o_count (w_qcount)
    );

    assign o_out.valid         = w_qvalid;
    assign o_out.kind          = w_head.kind;
    assign o_out.field_start   = w_head.field_start;
    assign o_out.field_length  = w_head.field_length;
    assign o_out.record_number = w_head.record_number;
    assign o_out.field_number  = w_head.field_number;
    assign o_out.closes_record = w_head.closes_record;
    assign o_out.error_code    = w_head.error_code;
    assign o_out.record_total  = w_head.record_total;
    assign o_out.fields_each   = w_head.fields_each;
    assign o_out.char_total    = w_head.char_total;
    assign o_out.last          = w_head.last;

endmodule

// ===== dv/brace_record_field_tokenizer_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the brace record field tokenizer: directed strings, limits, random strings.
module brace_record_field_tokenizer_top_test;
    import brft_pkg::*;

    localparam int MAX_CHARS    = 4096;
    localparam int MAX_RECORDS  = 256;
    localparam int MAX_FIELDS   = 256;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_QUOTA = 60;

    logic i_clk;
    logic i_rst_n;

    brft_in_if  in_if ();
    brft_out_if out_if ();

    brace_record_field_tokenizer_top #(
        .MAX_CHARS   (MAX_CHARS),
        .MAX_RECORDS (MAX_RECORDS),
        .MAX_FIELDS  (MAX_FIELDS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // parser mirror
    logic [2:0]  ph;
    int unsigned pos, tstart, smark, fcnt, rcnt, fexp, csum;
    bit          smark_ok;

    t_result pending_results[$];
    t_result step_res[$];
    t_result head_res;
    logic [7:0] text[$];

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int live_items;
    int strings_sent;
    int tokens_seen;
    int status_seen;
    int cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("** brace_record_field_tokenizer_top: FAILED **");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic bit is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
    endfunction

    function automatic void rearm_parser();
        ph = PH_START;
        pos = 0; tstart = 0; smark = 0; smark_ok = 1'b0;
        fcnt = 0; rcnt = 0; fexp = 0; csum = 0;
    endfunction

    function automatic void push_status(input bit ok, input logic [2:0] code);
        t_result r;
        r = '0;
        r.kind         = ok ? KIND_OK : KIND_ERR;
        r.error_code   = ok ? ERR_NO_LEADER : code;
        r.record_total = rcnt[7:0];
        r.fields_each  = fexp[7:0];
        r.char_total   = csum[12:0];
        step_res.push_back(r);
    endfunction

    function automatic void close_field(input logic [7:0] c, input int unsigned cur);
        t_result     r;
        int unsigned len;
        len = ((smark_ok ? smark : cur) - tstart) & 32'h000F_FFFF;
        if (fcnt + 1 >= MAX_FIELDS) begin
            push_status(1'b0, ERR_OVERFLOW);
            ph = PH_DEAD;
            return;
        end
        csum = (csum + len + 1) & 32'h001F_FFFF;
        r = '0;
        r.kind          = KIND_TOKEN;
        r.field_start   = tstart[11:0];
        r.field_length  = len[11:0];
        r.record_number = rcnt[7:0];
        r.field_number  = fcnt[7:0];
        r.closes_record = (c == CH_RBRACE);
        step_res.push_back(r);
        fcnt++;
        if (c == CH_COMMA) begin
            ph = PH_FWS;
            tstart = cur + 1;
            return;
        end
        if (rcnt + 1 >= MAX_RECORDS) begin
            push_status(1'b0, ERR_OVERFLOW);
            ph = PH_DEAD;
            return;
        end
        rcnt++;
        if (fexp == 0) begin
            fexp = fcnt;
        end else if (fexp != fcnt) begin
            push_status(1'b0, ERR_MISMATCH);
            ph = PH_DEAD;
            return;
        end
        ph = PH_SEEK;
    endfunction

    function automatic void end_of_string();
        int unsigned len;
        case (ph)
            PH_START: push_status(pos == 0, ERR_NO_LEADER);
            PH_FWS: begin
                if (pos == tstart) begin
                    if (rcnt + 1 >= MAX_RECORDS) begin
                        push_status(1'b0, ERR_OVERFLOW);
                    end else begin
                        rcnt++;
                        push_status(1'b0, ERR_UNTERM);
                    end
                end else begin
                    csum = (csum + 1) & 32'h001F_FFFF;
                    push_status(1'b0, ERR_BAD_TERM);
                end
            end
            PH_FIELD, PH_ESC: begin
                len = (((ph == PH_FIELD) && smark_ok) ? smark : pos) - tstart;
                csum = (csum + (len & 32'h000F_FFFF) + 1) & 32'h001F_FFFF;
                push_status(1'b0, ERR_BAD_TERM);
            end
            PH_SEEK: push_status(1'b1, ERR_NO_LEADER);
            default: ;
        endcase
        rearm_parser();
    endfunction

    function automatic void take_char(input logic [7:0] c);
        int unsigned cur;
        cur = pos;
        if (ph == PH_DEAD) return;
        if (cur >= MAX_CHARS - 1) begin
            push_status(1'b0, ERR_OVERFLOW);
            ph = PH_DEAD;
            return;
        end
        pos = cur + 1;
        case (ph)
            PH_START, PH_SEEK: begin
                if (c == CH_LBRACE) begin
                    ph = PH_FWS;
                    fcnt = 0;
                    tstart = cur + 1;
                end else if (ph == PH_START && !is_blank(c)) begin
                    push_status(1'b0, ERR_NO_LEADER);
                    ph = PH_DEAD;
                end
                return;
            end
            PH_FWS: begin
                if (is_blank(c)) return;
                tstart = cur;
                smark_ok = 1'b0;
                ph = PH_FIELD;
            end
            PH_ESC: begin
                ph = PH_FIELD;
                return;
            end
            default: ;
        endcase
        if (c == CH_BSLASH) begin
            smark_ok = 1'b0;
            ph = PH_ESC;
        end else if (c == CH_COMMA || c == CH_RBRACE) begin
            close_field(c, cur);
        end else if (is_blank(c)) begin
            if (!smark_ok) begin
                smark = cur;
                smark_ok = 1'b1;
            end
        end else begin
            smark_ok = 1'b0;
        end
    endfunction

    // works out the results of one accepted character and queues them
    function automatic void tokenize_char(input logic [7:0] c);
        step_res.delete();
        if (c == CH_NUL) end_of_string();
        else take_char(c);
        if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
        foreach (step_res[i]) pending_results.push_back(step_res[i]);
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result with nothing pending, kind %0d", $time, out_if.kind);
            end else begin
                head_res = pending_results.pop_front();
                if (head_res.kind == KIND_TOKEN) tokens_seen++;
                else status_seen++;
                compare_field("kind", head_res.kind, out_if.kind);
                compare_field("field_start", head_res.field_start, out_if.field_start);
                compare_field("field_length", head_res.field_length, out_if.field_length);
                compare_field("record_number", head_res.record_number, out_if.record_number);
                compare_field("field_number", head_res.field_number, out_if.field_number);
                compare_field("closes_record", head_res.closes_record, out_if.closes_record);
                compare_field("error_code", head_res.error_code, out_if.error_code);
                compare_field("record_total", head_res.record_total, out_if.record_total);
                compare_field("fields_each", head_res.fields_each, out_if.fields_each);
                compare_field("char_total", head_res.char_total, out_if.char_total);
                compare_field("last", head_res.last, out_if.last);
            end
        end
    end

    // one character transfer; valid stays high until the next falling edge
    task automatic send_char(input logic [7:0] c);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.char_code <= c;
        do @(posedge i_clk); while (!in_if.ready);
        if (c == CH_NUL || ph != PH_DEAD) live_items++;
        if (c == CH_NUL) strings_sent++;
        tokenize_char(c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
        send_char(CH_NUL);
    endtask

    task automatic send_queue();
        foreach (text[i]) send_char(text[i]);
    endtask

    // sender holds off until every queued result has arrived
    task automatic drain_results();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_NL;
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == CH_COMMA || c == CH_RBRACE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic void add_field_char();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            text.push_back(CH_BSLASH);
            text.push_back(8'($urandom_range(1, 255)));
        end else if (sel < 35) begin
            text.push_back(pick_blank());
        end else if (sel < 50) begin
            text.push_back(plain_char());
        end else begin
            text.push_back(8'($urandom_range(97, 122)));
        end
    endfunction

    // well-formed records with random content; now and then a record of another width
    function automatic void compose_records();
        int         nrec, nfld, f;
        logic [7:0] j;
        text.delete();
        repeat ($urandom_range(2)) text.push_back(pick_blank());
        nrec = $urandom_range(1, 4);
        nfld = $urandom_range(1, 4);
        for (int r = 0; r < nrec; r++) begin
            text.push_back(CH_LBRACE);
            f = ($urandom_range(9) == 0) ? $urandom_range(1, 5) : nfld;
            for (int k = 0; k < f; k++) begin
                repeat ($urandom_range(2)) text.push_back(pick_blank());
                repeat ($urandom_range(5)) add_field_char();
                repeat ($urandom_range(1)) text.push_back(pick_blank());
                text.push_back((k == f - 1) ? CH_RBRACE : CH_COMMA);
            end
            repeat ($urandom_range(3)) begin
                do j = 8'($urandom_range(1, 255)); while (j == CH_LBRACE);
                text.push_back(j);
            end
        end
        text.push_back(CH_NUL);
    endfunction

    task automatic test_empty_string();
        send_text("");
        drain_results();
    endtask

    task automatic test_well_formed();
        send_text(" \t{a, bc }\n{ d\\,e\\ , f\\\\}x}{\\}, \t}");
        send_text("{}");
        drain_results();
    endtask

    task automatic test_missing_leader();
        send_text("x{a}");
        send_text(" \n");
        drain_results();
    endtask

    task automatic test_end_inside_field();
        send_text("{ab ");
        send_text("{a\\");
        send_text("{a,\t");
        drain_results();
    endtask

    task automatic test_unterminated();
        send_text("{");
        send_text("{a}{b,");
        drain_results();
    endtask

    task automatic test_count_mismatch();
        send_text("{a,b}{}x");
        drain_results();
    endtask

    task automatic test_byte_extremes();
        send_char(CH_LBRACE);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(8'h01);
        send_char(8'h7F);
        send_char(CH_RBRACE);
        send_char(CH_NUL);
        drain_results();
    endtask

    // empty fields keep the string short
    task automatic test_field_overflow();
        send_char(CH_LBRACE);
        repeat (MAX_FIELDS) send_char(CH_COMMA);
        send_char(CH_NUL);
        drain_results();
    endtask

    task automatic test_record_overflow();
        repeat (MAX_RECORDS) begin
            send_char(CH_LBRACE);
            send_char(CH_RBRACE);
        end
        send_char(CH_NUL);
        drain_results();
    endtask

    task automatic test_random_strings(input int idle_pct, input int stall_pct);
        int start_live;
        int sel;
        int keep;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_live     = live_items;
        while (live_items - start_live < RANDOM_QUOTA) begin
            sel = $urandom_range(99);
            compose_records();
            if (sel < 15) begin
                // broken string: cut short before its end
                keep = $urandom_range(0, text.size() - 2);
                while (text.size() > keep) void'(text.pop_back());
                text.push_back(CH_NUL);
            end else if (sel < 30) begin
                text.delete();
                if ($urandom_range(1)) text.push_back(CH_LBRACE);
                repeat ($urandom_range(1, 10)) text.push_back(8'($urandom_range(1, 255)));
                text.push_back(CH_NUL);
            end
            send_queue();
        end
        drain_results();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.char_code = CH_NUL;
        out_if.ready    = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        fail_count      = 0;
        live_items      = 0;
        strings_sent    = 0;
        tokens_seen     = 0;
        status_seen     = 0;
        cycles          = 0;
        rearm_parser();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_string();
        test_well_formed();
        test_missing_leader();
        test_end_inside_field();
        test_unterminated();
        test_count_mismatch();
        test_byte_extremes();

        send_idle_pct  = 11;
        recv_stall_pct = 11;
        test_field_overflow();
        test_record_overflow();

        test_random_strings(0, 0);
        test_random_strings(73, 0);
        test_random_strings(0, 73);
        test_random_strings(11, 11);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            fail_count++;
            $display("%0d expected results never arrived", pending_results.size());
        end

        $display("Covered %0d strings (%0d live characters): directed cases, field and record",
                 strings_sent, live_items);
        $display("limits, random strings under four stall mixes; %0d tokens, %0d status.",
                 tokens_seen, status_seen);
        if (fail_count == 0) begin
            $display("** brace_record_field_tokenizer_top: PASSED **");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("** brace_record_field_tokenizer_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/brft_pkg.sv
design/brft_in_if.sv
design/brft_out_if.sv
design/brft_out_queue.sv
design/brace_record_field_tokenizer_top.sv
dv/brace_record_field_tokenizer_top_test.sv
